FILE: design/hcas_pkg.sv
`default_nettype none
package hcas_pkg;

  localparam int CubeDim   = 5;
  localparam int CubeVerts = 32;
  localparam logic [CubeVerts-1:0] AllVerts = 32'hFFFF_FFFF;

  typedef logic [2:0] coord_t;
  // perm[b] is the old coordinate that becomes new coordinate b
  typedef coord_t [CubeDim-1:0] perm_t;

  localparam perm_t PermIdentity = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
  // 4,3,2,1,0: the last permutation in lexicographic order
  localparam perm_t PermLast     = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

  typedef enum logic [1:0] {
    OUT_TRANSLATION = 2'd0,
    OUT_FLIP_PERM   = 2'd1,
    OUT_NONE        = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } ctl_state_t;

  // one permutation entering the evaluation pipe
  typedef struct packed {
    logic  valid;
    logic  last;
    logic  first;
    perm_t perm;
  } issue_t;

  // verdict for one permutation leaving the evaluation pipe
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       first;
    logic       found;
    logic [4:0] flip;
    perm_t      perm;
  } hit_t;

  // Next permutation in lexicographic order; not called on PermLast.
  function automatic perm_t next_perm(perm_t p);
    perm_t      r;
    perm_t      q;
    logic [2:0] piv;
    logic [2:0] sw;
    logic [2:0] src;
    coord_t     tmp;
    piv = '0;
    for (int i = 0; i < CubeDim - 1; i++) begin
      if (p[i] < p[i+1]) piv = 3'(i);
    end
    sw = '0;
    for (int j = 0; j < CubeDim; j++) begin
      if ((3'(j) > piv) && (p[j] > p[piv])) sw = 3'(j);
    end
    r       = p;
    tmp     = r[piv];
    r[piv]  = r[sw];
    r[sw]   = tmp;
    q       = r;
    for (int k = 0; k < CubeDim; k++) begin
      src = 3'(int'(piv) + CubeDim - k);
      if (3'(k) > piv) q[k] = r[src];
    end
    return q;
  endfunction

endpackage
`default_nettype wire

FILE: design/hcas_vset_if.sv
`default_nettype none
interface hcas_vset_if;
  logic        valid;
  logic        ready;
  logic [31:0] vertex_set;

  modport source (output valid, output vertex_set, input ready);
  modport sink   (input valid, input vertex_set, output ready);
endinterface
`default_nettype wire

FILE: design/hcas_res_if.sv
`default_nettype none
interface hcas_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [4:0] flip_xor;
  logic [2:0] perm_0;
  logic [2:0] perm_1;
  logic [2:0] perm_2;
  logic [2:0] perm_3;
  logic [2:0] perm_4;

  modport source (output valid, output outcome, output flip_xor, output perm_0,
                  output perm_1, output perm_2, output perm_3, output perm_4,
                  input ready);
  modport sink   (input valid, input outcome, input flip_xor, input perm_0,
                  input perm_1, input perm_2, input perm_3, input perm_4,
                  output ready);
endinterface
`default_nettype wire

FILE: design/hypercube_complement_automorphism_search_top.sv
`default_nettype none
// Channel  Dir  Word fields
// -------  ---  ------------------------------------------------------------
// vset     in   vertex_set[31:0]
// res      out  outcome[1:0], flip_xor[4:0], perm_0..perm_4[2:0]
//
// Flow: accept a set, then feed one permutation per cycle (120 at most) into the
// 3-stage evaluation pipe and hand the verdict on to the output register; the
// search ends early on a match, which also flushes the pipe.
// Reset clears the controller, the pipe valid bits and the result valid.
// A stalled result holds in the output register; the next set is accepted
// and searched while it waits.
module hypercube_complement_automorphism_search_top (
  input  logic              clk,
  input  logic              rst,
  hcas_vset_if.sink         vset,
  hcas_res_if.source        res
);

  hcas_pkg::ctl_state_t state;
  hcas_pkg::ctl_state_t state_next;

  logic [31:0]          set_bits;     // set under search, held for the whole search
  hcas_pkg::perm_t      perm_issue;   // next permutation to feed
  logic                 issuing;      // permutations left to feed

  hcas_pkg::issue_t     issue;
  hcas_pkg::hit_t       hit;
  logic                 flush;
  logic                 load_pend;
  logic                 load_out;

  // verdict of the finished search, waiting for the output register
  hcas_pkg::outcome_t   pend_outcome;
  logic [4:0]           pend_flip;
  hcas_pkg::perm_t      pend_perm;

  // output register
  logic                 res_valid;
  hcas_pkg::outcome_t   res_outcome;
  logic [4:0]           res_flip;
  hcas_pkg::perm_t      res_perm;

  // Feed one permutation per cycle while searching; flag the identity (a
  // match there is a pure translation) and the last one (its verdict ends the
  // search when nothing matched).
  always_comb begin
    issue.valid = (state == hcas_pkg::ST_SEARCH) && issuing;
    issue.last  = perm_issue == hcas_pkg::PermLast;
    issue.first = perm_issue == hcas_pkg::PermIdentity;
    issue.perm  = perm_issue;
  end

  hcas_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .flush    (flush),
    .set_bits (set_bits),
    .issue    (issue),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Verdicts leave the pipe in permutation order, so the first hit is the
  // answer. On a hit, drop everything still in flight.
  always_comb begin
    state_next = state;
    vset.ready = 1'b0;
    flush      = 1'b1;
    load_pend  = 1'b0;
    load_out   = 1'b0;
    case (state)
      hcas_pkg::ST_IDLE: begin
        vset.ready = 1'b1;
        if (vset.valid) state_next = hcas_pkg::ST_SEARCH;
      end
      hcas_pkg::ST_SEARCH: begin
        flush = 1'b0;
        if (hit.valid && hit.found) begin
          load_pend  = 1'b1;
          flush      = 1'b1;
          state_next = hcas_pkg::ST_DONE;
        end else if (hit.valid && hit.last) begin
          load_pend  = 1'b1;
          state_next = hcas_pkg::ST_DONE;
        end
      end
      hcas_pkg::ST_DONE: begin
        if (!res_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = hcas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hcas_pkg::ST_IDLE;
      end
    endcase
  end

  // Capture a new set and restart the permutation feed at the identity.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
    end else if (vset.valid && vset.ready) begin
      issuing <= 1'b1;
    end else if (issue.valid && issue.last) begin
      issuing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vset.valid && vset.ready) begin
      set_bits   <= vset.vertex_set;
      perm_issue <= hcas_pkg::PermIdentity;
    end else if (issue.valid && !issue.last) begin
      perm_issue <= hcas_pkg::next_perm(perm_issue);
    end
  end

  // Hold the verdict; no match reports flip 0 and the identity.
  always_ff @(posedge clk) begin
    if (load_pend) begin
      if (hit.found) begin
        pend_outcome <= hit.first ? hcas_pkg::OUT_TRANSLATION : hcas_pkg::OUT_FLIP_PERM;
        pend_flip    <= hit.flip;
        pend_perm    <= hit.perm;
      end else begin
        pend_outcome <= hcas_pkg::OUT_NONE;
        pend_flip    <= '0;
        pend_perm    <= hcas_pkg::PermIdentity;
      end
    end
  end

  // Output register: advance when empty or when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= load_out || (res_valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_outcome <= pend_outcome;
      res_flip    <= pend_flip;
      res_perm    <= pend_perm;
    end
  end

  assign res.valid     = res_valid;
  assign res.outcome   = res_outcome;
  assign res.flip_xor  = res_flip;
  assign res.perm_0    = res_perm[0];
  assign res.perm_1    = res_perm[1];
  assign res.perm_2    = res_perm[2];
  assign res.perm_3    = res_perm[3];
  assign res.perm_4    = res_perm[4];

endmodule
`default_nettype wire

FILE: design/hcas_pipe.sv
`default_nettype none
// Three-stage evaluation of one coordinate permutation against all 32 flips.
module hcas_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  flush,
  input  logic [31:0]           set_bits,
  input  hcas_pkg::issue_t      issue,
  output hcas_pkg::hit_t        hit
);

  // stage 1: permuted image of the set
  logic                  s1_valid;
  logic                  s1_last;
  logic                  s1_first;
  hcas_pkg::perm_t       s1_perm;
  logic [31:0]           s1_img;
  logic [31:0]           img;

  // stage 2: match per translated flip g = perm(flip)
  logic                  s2_valid;
  logic                  s2_last;
  logic                  s2_first;
  hcas_pkg::perm_t       s2_perm;
  logic [31:0]           s2_match;
  logic [31:0]           match;

  // stage 3: lowest flip that matches
  logic [31:0]           by_flip;
  logic                  found;
  logic [4:0]            flip;

  always_comb begin : perm_image
    logic [4:0] dst;
    logic [4:0] src;
    img = '0;
    for (int n = 0; n < hcas_pkg::CubeVerts; n++) begin
      dst = 5'(n);
      src = '0;
      for (int b = 0; b < hcas_pkg::CubeDim; b++) begin
        if (dst[b]) src = src | (5'd1 << issue.perm[b]);
      end
      img[n] = set_bits[src];
    end
  end

  always_comb begin : flip_compare
    logic [31:0] eq;
    for (int g = 0; g < hcas_pkg::CubeVerts; g++) begin
      for (int w = 0; w < hcas_pkg::CubeVerts; w++) begin
        eq[w] = s1_img[5'(w) ^ 5'(g)] != set_bits[w];
      end
      match[g] = &eq;
    end
  end

  always_comb begin : flip_select
    logic [4:0] f5;
    logic [4:0] g5;
    for (int f = 0; f < hcas_pkg::CubeVerts; f++) begin
      f5 = 5'(f);
      for (int b = 0; b < hcas_pkg::CubeDim; b++) begin
        g5[b] = f5[s2_perm[b]];
      end
      by_flip[f] = s2_match[g5];
    end
    found = |by_flip;
    flip  = '0;
    for (int f = hcas_pkg::CubeVerts - 1; f >= 0; f--) begin
      if (by_flip[f]) flip = 5'(f);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      hit.valid <= 1'b0;
    end else begin
      s1_valid  <= issue.valid;
      s2_valid  <= s1_valid;
      hit.valid <= s2_valid;
    end
    s1_last    <= issue.last;
    s1_first   <= issue.first;
    s1_perm    <= issue.perm;
    s1_img     <= img;
    s2_last    <= s1_last;
    s2_first   <= s1_first;
    s2_perm    <= s1_perm;
    s2_match   <= match;
    hit.last   <= s2_last;
    hit.first  <= s2_first;
    hit.perm   <= s2_perm;
    hit.found  <= found;
    hit.flip   <= flip;
  end

endmodule
`default_nettype wire

FILE: design/hcas_chk.sv
`default_nettype none
module hcas_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       vset_valid,
  input wire logic       vset_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [1:0] res_outcome,
  input wire logic [4:0] res_flip_xor,
  input wire logic [2:0] res_perm_0,
  input wire logic [2:0] res_perm_1,
  input wire logic [2:0] res_perm_2,
  input wire logic [2:0] res_perm_3,
  input wire logic [2:0] res_perm_4
);

  logic perm_is_identity;
  assign perm_is_identity = (res_perm_0 == 3'd0) && (res_perm_1 == 3'd1) &&
                            (res_perm_2 == 3'd2) && (res_perm_3 == 3'd3) &&
                            (res_perm_4 == 3'd4);

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_outcome) &&
    $stable(res_flip_xor) && $stable({res_perm_0, res_perm_1, res_perm_2,
                                      res_perm_3, res_perm_4}))
    else $error("result word changed while stalled");

  // one set at a time: the search starts right after an accept
  a_one_search: assert property (@(posedge clk) disable iff (rst)
    vset_valid && vset_ready |=> !vset_ready)
    else $error("input taken again during a search");

  a_none_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_outcome == hcas_pkg::OUT_NONE) |->
    (res_flip_xor == 5'd0) && perm_is_identity)
    else $error("no-match result without zero flip and identity");

  a_trans_perm: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_outcome == hcas_pkg::OUT_TRANSLATION) |-> perm_is_identity)
    else $error("translation result with a non-identity permutation");

  a_flip_perm: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_outcome == hcas_pkg::OUT_FLIP_PERM) |-> !perm_is_identity)
    else $error("flip-plus-permutation result with the identity");

endmodule

bind hypercube_complement_automorphism_search_top hcas_chk u_hcas_chk (
  .clk           (clk),
  .rst           (rst),
  .vset_valid    (vset.valid),
  .vset_ready    (vset.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_outcome   (res.outcome),
  .res_flip_xor  (res.flip_xor),
  .res_perm_0    (res.perm_0),
  .res_perm_1    (res.perm_1),
  .res_perm_2    (res.perm_2),
  .res_perm_3    (res.perm_3),
  .res_perm_4    (res.perm_4)
);
`default_nettype wire
